[design/brent_root_finder_unit_defines.svh]
// Assertion macros for the Brent root finder.
`ifndef BRENT_ROOT_FINDER_UNIT_DEFINES_SVH
`define BRENT_ROOT_FINDER_UNIT_DEFINES_SVH
// Implication check clocked on the rising edge, quiet during reset.
`define BRF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("brent root finder check failed");
// Next-cycle implication check.
`define BRF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("brent root finder check failed");
`endif

[design/brf_pkg.sv]
// Package with types, constants and saturating helpers for the Brent root finder.
`default_nettype none
package brf_pkg;
    localparam int VW = 32;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef logic signed [VW-1:0] val_t;

    typedef enum logic [1:0] {
        ST_EVAL = 2'd0, ST_ROOT = 2'd1, ST_BAD = 2'd2, ST_UNEXP = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_LOWER = 2'd0, REG_UPPER = 2'd1, REG_TOL = 2'd2, REG_ITER = 2'd3
    } reg_idx_t;

    typedef enum logic [5:0] {
        S_IDLE, S_WAIT_A, S_WAIT_B, S_WAIT_S,
        S_NP_START,
        S_T1_M1, S_T1_M2, S_T1_D1, S_T1_D2,
        S_T2_M1, S_T2_M2, S_T2_D1, S_T2_D2,
        S_T3_M1, S_T3_M2, S_T3_D1, S_T3_D2,
        S_SC_M1, S_SC_D1,
        S_NP_TEST, S_EMIT
    } state_t;

    typedef enum logic {
        OP_MUL = 1'b0, OP_DIV = 1'b1
    } aop_t;

    // Request to and reply from the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        aop_t op;
    } au_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } au_rsp_t;

    function automatic val_t sat_add(val_t x, val_t y);
        logic signed [VW:0] s;
        s = {x[VW-1], x} + {y[VW-1], y};
        if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic val_t sat_sub(val_t x, val_t y);
        logic signed [VW:0] s;
        s = {x[VW-1], x} - {y[VW-1], y};
        if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic val_t sat_abs(val_t x);
        if (x == VMIN) return VMAX;
        return x[VW-1] ? -x : x;
    endfunction

    function automatic val_t floor_avg(val_t x, val_t y);
        logic signed [VW:0] s;
        s = {x[VW-1], x} + {y[VW-1], y};
        return s[VW:1];
    endfunction

    function automatic logic opposite(val_t x, val_t y);
        return (x[VW-1] && !y[VW-1] && y != '0) || (y[VW-1] && !x[VW-1] && x != '0);
    endfunction
endpackage
`default_nettype wire

[design/brf_arith.sv]
// Shared Q16.16 multiply and bit-serial divide unit with saturation.
`default_nettype none
module brf_arith (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire brf_pkg::au_req_t req,
    input  wire brf_pkg::val_t  x,
    input  wire brf_pkg::val_t  y,
    output brf_pkg::au_rsp_t    rsp,
    output brf_pkg::val_t       result
);
    localparam int VW = brf_pkg::VW;
    localparam int NB = VW + 16;
    localparam int CW = $clog2(NB + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    brf_pkg::aop_t     op_reg, op_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [NB-1:0]     num_reg, num_next;
    logic [VW:0]       dv_reg, dv_next;
    logic [VW:0]       rem_reg, rem_next;
    logic [NB-1:0]     quo_reg, quo_next;
    logic [2*VW-1:0]   prod_reg, prod_next;
    brf_pkg::val_t     res_reg, res_next;

    logic [VW-1:0] ux, uy;
    logic [VW:0]   rsh;
    logic [NB-1:0] mag;
    logic          ovf;

    function automatic brf_pkg::val_t from_mag(logic neg, logic [NB-1:0] m, logic o);
        if (!neg) return (o || m > NB'(brf_pkg::VMAX)) ? brf_pkg::VMAX : m[VW-1:0];
        if (o || m > NB'(brf_pkg::VMAX) + NB'(1)) return brf_pkg::VMIN;
        return -m[VW-1:0];
    endfunction

    always_comb begin
        ux = x[VW-1] ? -x : x;
        uy = y[VW-1] ? -y : y;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next = op_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        dv_next = dv_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        prod_next = prod_reg;
        res_next = res_reg;
        rsh = '0;
        mag = '0;
        ovf = 1'b0;
        if (req.start) begin
            op_next = req.op;
            neg_next = x[VW-1] ^ y[VW-1];
            busy_next = 1'b1;
            if (req.op == brf_pkg::OP_MUL) begin
                prod_next = ux * uy;
                cnt_next = '0;
            end else if (x == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next = '0;
            end else if (y == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next = x[VW-1] ? brf_pkg::VMIN : brf_pkg::VMAX;
            end else begin
                num_next = {ux, 16'h0000};
                dv_next = {1'b0, uy};
                rem_next = '0;
                quo_next = '0;
                cnt_next = CW'(NB);
            end
        end else if (busy_reg) begin
            if (op_reg == brf_pkg::OP_MUL) begin
                mag = NB'(prod_reg[2*VW-1:16]);
                ovf = prod_reg[2*VW-1:VW+16] != '0;
                res_next = from_mag(neg_reg, mag, ovf);
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (cnt_reg != '0) begin
                rsh = {rem_reg[VW-1:0], num_reg[NB-1]};
                num_next = {num_reg[NB-2:0], 1'b0};
                if (rsh >= dv_reg) begin
                    rem_next = rsh - dv_reg;
                    quo_next = {quo_reg[NB-2:0], 1'b1};
                end else begin
                    rem_next = rsh;
                    quo_next = {quo_reg[NB-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
            end else begin
                res_next = from_mag(neg_reg, quo_reg, 1'b0);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg <= op_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        dv_reg <= dv_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        prod_reg <= prod_next;
        res_reg <= res_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire

[design/brent_root_finder_unit.sv]
// Top level of the Brent root finder: handshakes, configuration and step sequencer.
`default_nettype none
// The block asks for function values and searches for a root of that function by
// Brent's method in Q16.16. A start beat (operation 0) loads the bracket from the
// lower_limit and upper_limit registers and returns the lower point to evaluate;
// each value beat (operation 1) answers the last request. After both ends are known
// the block either reports a bad bracket (status 2) or runs Brent steps, each of
// which returns the next point to evaluate (status 0), until f is zero, the bracket
// is narrower than error_tolerance, or iteration_limit steps are done, when it
// returns the root estimate with status 1. A value beat while idle gives status 3.
// Bracket beats answer on the cycle after they are accepted. A beat that computes a
// new point is slower: all multiplies and divides go one at a time through one
// shared unit whose divider resolves one quotient bit per cycle, and an inverse
// quadratic step needs six of each while a secant step needs one of each.
// s_tready is low while a beat is being worked on or its result waits on the
// output register.
`include "brent_root_finder_unit_defines.svh"
module brent_root_finder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] function_value
    input  wire logic        s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] point
    output logic [1:0]       m_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    typedef brf_pkg::val_t val_t;

    val_t        lower_reg, upper_reg;
    logic [30:0] tol_reg;
    logic [3:0]  iter_lim_reg;

    brf_pkg::state_t state_reg, state_next;
    val_t a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    val_t fa_reg, fa_next, fb_reg, fb_next, fc_reg, fc_next, s_reg, s_next;
    val_t sum_reg, sum_next;
    logic bis_reg, bis_next;
    logic [3:0] cnt_reg, cnt_next;
    logic ov_reg, ov_next;
    logic [31:0] pt_reg, pt_next;
    logic [1:0]  st_reg, st_next;

    brf_pkg::au_req_t au_req;
    brf_pkg::au_rsp_t au_rsp;
    val_t au_x, au_y, au_res;

    logic in_fire, cfg_wr;
    val_t fv, q, sbv, bc, cd, s_w, tolv;
    logic c1, c2, c3, c4, c5;

    brf_arith u_arith (
        .aclk(aclk), .aresetn(aresetn), .req(au_req), .x(au_x), .y(au_y),
        .rsp(au_rsp), .result(au_res)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= '0;
            upper_reg <= 32'sd65536;
            tol_reg <= 31'd66;
            iter_lim_reg <= 4'd5;
        end else if (cfg_wr) begin
            case (brf_pkg::reg_idx_t'(paddr[3:2]))
                brf_pkg::REG_LOWER: lower_reg <= pwdata;
                brf_pkg::REG_UPPER: upper_reg <= pwdata;
                brf_pkg::REG_TOL:   tol_reg <= pwdata[30:0];
                brf_pkg::REG_ITER:  iter_lim_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (brf_pkg::reg_idx_t'(paddr[3:2]))
            brf_pkg::REG_LOWER: prdata = lower_reg;
            brf_pkg::REG_UPPER: prdata = upper_reg;
            brf_pkg::REG_TOL:   prdata = {1'b0, tol_reg};
            brf_pkg::REG_ITER:  prdata = {28'd0, iter_lim_reg};
            default:            prdata = '0;
        endcase
    end

    // Input is taken only in the resting states with no pending output.
    assign s_tready = !m_tvalid && (state_reg == brf_pkg::S_IDLE ||
        state_reg == brf_pkg::S_WAIT_A || state_reg == brf_pkg::S_WAIT_B ||
        state_reg == brf_pkg::S_WAIT_S);
    assign in_fire = s_tvalid && s_tready;
    assign fv = s_tdata;
    assign tolv = {1'b0, tol_reg};

    // Bisection fallback tests on the interpolated point held in sum_reg.
    always_comb begin
        s_w = sum_reg;
        q = brf_pkg::floor_avg(a_reg, brf_pkg::floor_avg(a_reg, b_reg));
        sbv = brf_pkg::sat_abs(brf_pkg::sat_sub(s_w, b_reg));
        bc = brf_pkg::sat_abs(brf_pkg::sat_sub(b_reg, c_reg));
        cd = brf_pkg::sat_abs(brf_pkg::sat_sub(c_reg, d_reg));
        c1 = (s_w < q && s_w < b_reg) || (s_w > q && s_w > b_reg);
        c2 = bis_reg && sbv >= (bc >>> 1);
        c3 = !bis_reg && sbv >= (cd >>> 1);
        c4 = bis_reg && bc < tolv;
        c5 = !bis_reg && cd < tolv;
    end

    always_comb begin
        state_next = state_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        fa_next = fa_reg; fb_next = fb_reg; fc_next = fc_reg; s_next = s_reg;
        sum_next = sum_reg; bis_next = bis_reg;
        cnt_next = cnt_reg; ov_next = ov_reg; pt_next = pt_reg; st_next = st_reg;
        au_req = '{start: 1'b0, op: brf_pkg::OP_MUL};
        au_x = '0;
        au_y = '0;
        if (m_tvalid && m_tready) ov_next = 1'b0;
        if (in_fire) begin
            ov_next = 1'b1;
            if (!s_tuser) begin
                a_next = lower_reg;
                b_next = upper_reg;
                pt_next = lower_reg;
                st_next = brf_pkg::ST_EVAL;
                state_next = brf_pkg::S_WAIT_A;
            end else begin
                case (state_reg)
                    brf_pkg::S_WAIT_A: begin
                        fa_next = fv;
                        pt_next = b_reg;
                        st_next = brf_pkg::ST_EVAL;
                        state_next = brf_pkg::S_WAIT_B;
                    end
                    brf_pkg::S_WAIT_B: begin
                        if (!brf_pkg::opposite(fa_reg, fv)) begin
                            pt_next = '0;
                            st_next = brf_pkg::ST_BAD;
                            state_next = brf_pkg::S_IDLE;
                        end else begin
                            ov_next = 1'b0;
                            if (brf_pkg::sat_abs(fa_reg) < brf_pkg::sat_abs(fv)) begin
                                a_next = b_reg; b_next = a_reg;
                                fa_next = fv; fb_next = fa_reg;
                                c_next = b_reg; fc_next = fv;
                            end else begin
                                fb_next = fv;
                                c_next = a_reg; fc_next = fa_reg;
                            end
                            d_next = brf_pkg::sat_add(upper_reg, upper_reg / 4);
                            bis_next = 1'b1;
                            cnt_next = '0;
                            state_next = brf_pkg::S_NP_START;
                        end
                    end
                    brf_pkg::S_WAIT_S: begin
                        d_next = c_reg;
                        c_next = b_reg;
                        fc_next = fb_reg;
                        a_next = a_reg; b_next = b_reg; fa_next = fa_reg; fb_next = fb_reg;
                        if (brf_pkg::opposite(fa_reg, fv)) begin
                            if (brf_pkg::sat_abs(fa_reg) < brf_pkg::sat_abs(fv)) begin
                                a_next = s_reg; fa_next = fv; b_next = a_reg; fb_next = fa_reg;
                            end else begin
                                b_next = s_reg; fb_next = fv;
                            end
                        end else begin
                            if (brf_pkg::sat_abs(fv) < brf_pkg::sat_abs(fb_reg)) begin
                                a_next = b_reg; fa_next = fb_reg; b_next = s_reg; fb_next = fv;
                            end else begin
                                a_next = s_reg; fa_next = fv;
                            end
                        end
                        cnt_next = cnt_reg + 4'd1;
                        if (fv == '0 ||
                            brf_pkg::sat_abs(brf_pkg::sat_sub(b_next, a_next)) < tolv ||
                            cnt_next >= iter_lim_reg) begin
                            pt_next = b_next;
                            st_next = brf_pkg::ST_ROOT;
                            state_next = brf_pkg::S_IDLE;
                        end else begin
                            ov_next = 1'b0;
                            state_next = brf_pkg::S_NP_START;
                        end
                    end
                    default: begin
                        pt_next = '0;
                        st_next = brf_pkg::ST_UNEXP;
                    end
                endcase
            end
        end else begin
            case (state_reg)
                brf_pkg::S_NP_START: begin
                    sum_next = '0;
                    au_req = '{start: 1'b1, op: brf_pkg::OP_MUL};
                    if (fa_reg != fc_reg && fb_reg != fc_reg) begin
                        au_x = a_reg; au_y = fb_reg;
                        state_next = brf_pkg::S_T1_M1;
                    end else begin
                        au_x = fb_reg; au_y = brf_pkg::sat_sub(b_reg, a_reg);
                        state_next = brf_pkg::S_SC_M1;
                    end
                end
                brf_pkg::S_T1_M1, brf_pkg::S_T2_M1, brf_pkg::S_T3_M1: if (au_rsp.done) begin
                    au_req = '{start: 1'b1, op: brf_pkg::OP_MUL};
                    au_x = au_res;
                    au_y = (state_reg == brf_pkg::S_T3_M1) ? fb_reg : fc_reg;
                    state_next = brf_pkg::state_t'(state_reg + 1);
                end
                brf_pkg::S_T1_M2, brf_pkg::S_T2_M2, brf_pkg::S_T3_M2: if (au_rsp.done) begin
                    au_req = '{start: 1'b1, op: brf_pkg::OP_DIV};
                    au_x = au_res;
                    case (state_reg)
                        brf_pkg::S_T1_M2: au_y = brf_pkg::sat_sub(fa_reg, fb_reg);
                        brf_pkg::S_T2_M2: au_y = brf_pkg::sat_sub(fb_reg, fa_reg);
                        default:          au_y = brf_pkg::sat_sub(fc_reg, fa_reg);
                    endcase
                    state_next = brf_pkg::state_t'(state_reg + 1);
                end
                brf_pkg::S_T1_D1, brf_pkg::S_T2_D1, brf_pkg::S_T3_D1: if (au_rsp.done) begin
                    au_req = '{start: 1'b1, op: brf_pkg::OP_DIV};
                    au_x = au_res;
                    case (state_reg)
                        brf_pkg::S_T1_D1: au_y = brf_pkg::sat_sub(fa_reg, fc_reg);
                        brf_pkg::S_T2_D1: au_y = brf_pkg::sat_sub(fb_reg, fc_reg);
                        default:          au_y = brf_pkg::sat_sub(fc_reg, fb_reg);
                    endcase
                    state_next = brf_pkg::state_t'(state_reg + 1);
                end
                brf_pkg::S_T1_D2, brf_pkg::S_T2_D2: if (au_rsp.done) begin
                    sum_next = brf_pkg::sat_add(sum_reg, au_res);
                    au_req = '{start: 1'b1, op: brf_pkg::OP_MUL};
                    au_x = (state_reg == brf_pkg::S_T1_D2) ? b_reg : c_reg;
                    au_y = fa_reg;
                    state_next = brf_pkg::state_t'(state_reg + 1);
                end
                brf_pkg::S_T3_D2: if (au_rsp.done) begin
                    sum_next = brf_pkg::sat_add(sum_reg, au_res);
                    state_next = brf_pkg::S_NP_TEST;
                end
                brf_pkg::S_SC_M1: if (au_rsp.done) begin
                    au_req = '{start: 1'b1, op: brf_pkg::OP_DIV};
                    au_x = au_res;
                    au_y = brf_pkg::sat_sub(fb_reg, fa_reg);
                    state_next = brf_pkg::S_SC_D1;
                end
                brf_pkg::S_SC_D1: if (au_rsp.done) begin
                    sum_next = brf_pkg::sat_sub(b_reg, au_res);
                    state_next = brf_pkg::S_NP_TEST;
                end
                brf_pkg::S_NP_TEST: begin
                    if (c1 || c2 || c3 || c4 || c5) begin
                        s_next = brf_pkg::floor_avg(a_reg, b_reg);
                        bis_next = 1'b1;
                    end else begin
                        s_next = sum_reg;
                        bis_next = 1'b0;
                    end
                    state_next = brf_pkg::S_EMIT;
                end
                brf_pkg::S_EMIT: begin
                    pt_next = s_reg;
                    st_next = brf_pkg::ST_EVAL;
                    ov_next = 1'b1;
                    state_next = brf_pkg::S_WAIT_S;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brf_pkg::S_IDLE;
            ov_reg <= 1'b0;
            bis_reg <= 1'b1;
            cnt_reg <= '0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            fa_reg <= '0; fb_reg <= '0; fc_reg <= '0; s_reg <= '0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            bis_reg <= bis_next;
            cnt_reg <= cnt_next;
            a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
            fa_reg <= fa_next; fb_reg <= fb_next; fc_reg <= fc_next; s_reg <= s_next;
        end
        sum_reg <= sum_next;
        pt_reg <= pt_next;
        st_reg <= st_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata = pt_reg;
    assign m_tuser = st_reg;

    // A pending result blocks new input beats.
    `BRF_ASSERT_IMPL(a_no_accept_pending, aclk, aresetn, m_tvalid, !s_tready)
    // The shared unit is only started while it is idle.
    `BRF_ASSERT_IMPL(a_unit_free, aclk, aresetn, au_req.start, !au_rsp.busy)
    // A root report always ends the search.
    `BRF_ASSERT_NEXT(a_root_idle, aclk, aresetn,
        in_fire && st_next == brf_pkg::ST_ROOT, state_reg == brf_pkg::S_IDLE)
endmodule
`default_nettype wire
